// ----- rtl/core/single_source_shortest_paths_core_assert.svh -----
// assertion macros shared by the shortest path core
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_CORE_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_CORE_ASSERT_SVH

// implication checked every clock outside reset
`define SSSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define SSSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/sssp_pkg.sv -----
package sssp_pkg;

  localparam int MaxNodes   = 64;
  localparam int MaxEdges   = 512;
  localparam int WeightBits = 16;
  localparam int DistBits   = 24;
  localparam int NodeBits   = 6;
  localparam int EdgeBits   = 9;
  localparam int CountBits  = 10;

  localparam logic [DistBits-1:0] DistTop = '1;

  localparam logic [0:0] CmdAdd = 1'b0;
  localparam logic [0:0] CmdRun = 1'b1;

  localparam logic [0:0] RegNodeCount  = 1'b0;
  localparam logic [0:0] RegSourceNode = 1'b1;

  typedef struct packed {
    logic [NodeBits-1:0]   from_node;
    logic [NodeBits-1:0]   to_node;
    logic [WeightBits-1:0] weight;
  } edge_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_PICK,
    ST_EREAD,
    ST_EWAIT,
    ST_RELAX,
    ST_EMIT,
    ST_HOLD
  } state_t;

  // saturating add of distance and weight
  function automatic logic [DistBits-1:0] sat_add(input logic [DistBits-1:0] d,
                                                  input logic [WeightBits-1:0] w);
    logic [DistBits:0] s;
    s = {1'b0, d} + {{(DistBits+1-WeightBits){1'b0}}, w};
    return s[DistBits] ? DistTop : s[DistBits-1:0];
  endfunction

endpackage

// ----- rtl/core/sssp_edge_mem.sv -----
module sssp_edge_mem (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [sssp_pkg::EdgeBits-1:0]          wr_addr,
  input  sssp_pkg::edge_t                        wr_data,
  input  logic [sssp_pkg::EdgeBits-1:0]          rd_addr,
  output sssp_pkg::edge_t                        rd_data
);

  sssp_pkg::edge_t mem [sssp_pkg::MaxEdges];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/sssp_dist_mem.sv -----
module sssp_dist_mem (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [sssp_pkg::NodeBits-1:0]          wr_addr,
  input  logic [sssp_pkg::DistBits-1:0]          wr_data,
  input  logic [sssp_pkg::NodeBits-1:0]          rd_addr,
  output logic [sssp_pkg::DistBits-1:0]          rd_data
);

  logic [sssp_pkg::DistBits-1:0] mem [sssp_pkg::MaxNodes];

  // distance table, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/single_source_shortest_paths_core.sv -----
// channel | dir | fields (low bit first)
// in_     | in  | tdata: from_node[5:0] to_node[11:6] edge_weight[27:12]; tuser: cmd
// out_    | out | tdata: node_index[5:0] distance[29:6] reachable[30] edges_dropped[31];
//         |     | tlast: last
// cfg_    | in  | wr_en, index (0 node_count, 1 source_node), data[6:0]
// an add-edge item is accepted in idle, where in_tready stays high. a run item does
// an init step, then for each finished node a scan and an edge walk over all stored
// edges, one closing scan, then emits each result in turn, paced by the single distance
// memory port. a source outside the node count skips from init straight to the results.
// reset is synchronous, active low; the edge store is not cleared, a fill count
// tracks its contents. the output register holds while out_tready is low.
module single_source_shortest_paths_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // from_node, to_node, edge_weight
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // node_index, distance, reachable, edges_dropped
  output logic        out_tlast,  // last
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int NB = sssp_pkg::NodeBits;
  localparam int DB = sssp_pkg::DistBits;

  sssp_pkg::state_t state_r, state_nxt;

  logic [6:0]                        node_count_r;
  logic [NB-1:0]                     source_r;
  logic [sssp_pkg::CountBits-1:0]    edge_total_r, edge_total_nxt;
  logic                              overflow_r, overflow_nxt;
  logic [sssp_pkg::MaxNodes-1:0]     seen_r, seen_nxt, done_r, done_nxt;
  logic [6:0]                        n_r, n_nxt;
  logic [6:0]                        idx_r, idx_nxt;
  logic [sssp_pkg::CountBits-1:0]    eidx_r, eidx_nxt;
  logic [NB-1:0]                     u_r, u_nxt;
  logic [DB-1:0]                     ud_r, ud_nxt;
  logic                              found_r, found_nxt;
  logic [NB-1:0]                     cand_node_r, cand_node_nxt;
  logic                              cand_ok_r, cand_ok_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [31:0]                       out_data_r, out_data_nxt;
  logic                              out_last_r, out_last_nxt;

  // memory ports
  logic                              e_we;
  logic [sssp_pkg::EdgeBits-1:0]     e_waddr, e_raddr;
  sssp_pkg::edge_t                   e_wdata, e_rdata;
  logic                              d_we;
  logic [NB-1:0]                     d_waddr, d_raddr;
  logic [DB-1:0]                     d_wdata, d_rdata;

  sssp_edge_mem u_edge (
    .clk(clk), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
    .rd_addr(e_raddr), .rd_data(e_rdata)
  );

  sssp_dist_mem u_dist (
    .clk(clk), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
    .rd_addr(d_raddr), .rd_data(d_rdata)
  );

  logic [DB-1:0] relax_sum;
  logic [NB-1:0] idx6;
  logic [NB-1:0] prev6;
  logic          accept;
  logic          src_live;

  assign idx6   = idx_r[NB-1:0];
  assign prev6  = cand_node_r;
  assign accept = in_tvalid && in_tready;
  assign relax_sum = sssp_pkg::sat_add(ud_r, e_rdata.weight);
  assign src_live  = ({1'b0, source_r} < n_r);

  assign in_tready  = (state_r == sssp_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sssp_pkg::ST_IDLE:  if (accept && in_tuser == sssp_pkg::CmdRun) begin
        state_nxt = sssp_pkg::ST_INIT;
      end
      sssp_pkg::ST_INIT:  state_nxt = src_live ? sssp_pkg::ST_SCAN : sssp_pkg::ST_EMIT;
      sssp_pkg::ST_SCAN:  if (idx_r == n_r) state_nxt = sssp_pkg::ST_PICK;
      sssp_pkg::ST_PICK:  state_nxt = found_r ? sssp_pkg::ST_EREAD : sssp_pkg::ST_EMIT;
      sssp_pkg::ST_EREAD: state_nxt = (eidx_r >= edge_total_r) ? sssp_pkg::ST_SCAN
                                                               : sssp_pkg::ST_EWAIT;
      sssp_pkg::ST_EWAIT: state_nxt = sssp_pkg::ST_RELAX;
      sssp_pkg::ST_RELAX: state_nxt = sssp_pkg::ST_EREAD;
      sssp_pkg::ST_EMIT:  state_nxt = sssp_pkg::ST_HOLD;
      sssp_pkg::ST_HOLD:  if (!out_valid_r || out_tready) begin
        state_nxt = (idx_r + 7'd1 == n_r) ? sssp_pkg::ST_IDLE : sssp_pkg::ST_EMIT;
      end
      default:            state_nxt = sssp_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    edge_total_nxt = edge_total_r;
    overflow_nxt   = overflow_r;
    seen_nxt       = seen_r;
    done_nxt       = done_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    eidx_nxt       = eidx_r;
    u_nxt          = u_r;
    ud_nxt         = ud_r;
    found_nxt      = found_r;
    cand_node_nxt  = cand_node_r;
    cand_ok_nxt    = cand_ok_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    e_we    = 1'b0;
    e_waddr = edge_total_r[sssp_pkg::EdgeBits-1:0];
    e_wdata.from_node = in_tdata[5:0];
    e_wdata.to_node   = in_tdata[11:6];
    e_wdata.weight    = in_tdata[27:12];
    e_raddr = eidx_r[sssp_pkg::EdgeBits-1:0];
    d_we    = 1'b0;
    d_waddr = source_r;
    d_wdata = '0;
    d_raddr = idx6;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      sssp_pkg::ST_IDLE: begin
        if (accept && in_tuser == sssp_pkg::CmdAdd) begin
          if (edge_total_r < 10'(sssp_pkg::MaxEdges)) begin
            e_we = 1'b1;
            edge_total_nxt = edge_total_r + 10'd1;
          end else begin
            overflow_nxt = 1'b1;
          end
        end else if (accept) begin
          if (node_count_r == 7'd0) n_nxt = 7'd1;
          else if (node_count_r > 7'(sssp_pkg::MaxNodes)) n_nxt = 7'(sssp_pkg::MaxNodes);
          else n_nxt = node_count_r;
        end
      end
      sssp_pkg::ST_INIT: begin
        seen_nxt = '0;
        done_nxt = '0;
        idx_nxt  = '0;
        found_nxt = 1'b0;
        cand_ok_nxt = 1'b0;
        if (src_live) begin
          seen_nxt[source_r] = 1'b1;
          d_we = 1'b1;
        end
      end
      sssp_pkg::ST_SCAN: begin
        // compare the node read last cycle against the running minimum
        if (cand_ok_r && (!found_r || d_rdata < ud_r)) begin
          found_nxt = 1'b1;
          u_nxt     = prev6;
          ud_nxt    = d_rdata;
        end
        cand_node_nxt = idx6;
        cand_ok_nxt   = (idx_r < n_r) && seen_r[idx6] && !done_r[idx6];
        if (idx_r != n_r) idx_nxt = idx_r + 7'd1;
      end
      sssp_pkg::ST_PICK: begin
        cand_ok_nxt = 1'b0;
        eidx_nxt    = '0;
        if (found_r) done_nxt[u_r] = 1'b1;
      end
      sssp_pkg::ST_EREAD: begin
        d_raddr = e_rdata.to_node;
        if (eidx_r >= edge_total_r) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      sssp_pkg::ST_EWAIT: begin
        d_raddr = e_rdata.to_node;
      end
      sssp_pkg::ST_RELAX: begin
        // edge data and target distance are both ready here
        if (e_rdata.from_node == u_r && {1'b0, e_rdata.to_node} < n_r &&
            (!seen_r[e_rdata.to_node] || relax_sum < d_rdata)) begin
          seen_nxt[e_rdata.to_node] = 1'b1;
          d_we    = 1'b1;
          d_waddr = e_rdata.to_node;
          d_wdata = relax_sum;
        end
        eidx_nxt = eidx_r + 10'd1;
      end
      sssp_pkg::ST_EMIT: begin
        if (!src_live) begin
          seen_nxt = '0;
        end
      end
      sssp_pkg::ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {overflow_r, seen_r[idx6],
                           seen_r[idx6] ? d_rdata : {DB{1'b0}}, idx6};
          out_last_nxt  = (idx_r + 7'd1 == n_r);
          idx_nxt       = idx_r + 7'd1;
          if (idx_r + 7'd1 == n_r) begin
            edge_total_nxt = '0;
            overflow_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (state_r == sssp_pkg::ST_PICK && !found_r) idx_nxt = '0;
    if (state_r == sssp_pkg::ST_INIT && !src_live) idx_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sssp_pkg::ST_IDLE;
      node_count_r <= 7'd64;
      source_r     <= '0;
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_total_r <= edge_total_nxt;
      overflow_r   <= overflow_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en && cfg_index == sssp_pkg::RegNodeCount) node_count_r <= cfg_data;
      if (cfg_wr_en && cfg_index == sssp_pkg::RegSourceNode) source_r <= cfg_data[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    seen_r      <= seen_nxt;
    done_r      <= done_nxt;
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    eidx_r      <= eidx_nxt;
    u_r         <= u_nxt;
    ud_r        <= ud_nxt;
    found_r     <= found_nxt;
    cand_node_r <= cand_node_nxt;
    cand_ok_r   <= cand_ok_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  `include "single_source_shortest_paths_core_assert.svh"

  `SSSP_ASSERT_IMP(a_busy_not_ready, state_r != sssp_pkg::ST_IDLE, !in_tready)
  `SSSP_ASSERT_IMP(a_fill_bound, 1'b1, edge_total_r <= 10'(sssp_pkg::MaxEdges))
  `SSSP_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready,
                    out_valid_r && $stable(out_data_r))
  `SSSP_ASSERT_NEXT(a_last_clears,
                    state_r == sssp_pkg::ST_HOLD && (!out_valid_r || out_tready) &&
                    idx_r + 7'd1 == n_r,
                    state_r == sssp_pkg::ST_IDLE && edge_total_r == '0)

endmodule
